// ===== design/ils_pkg.sv =====
`timescale 1ns / 1ps

package ils_pkg;

  localparam int KIND_W = 3;
  localparam int POS_W  = 12;
  localparam int DATA_W = 32;

  localparam logic [KIND_W-1:0] KIND_READ   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_HEAD   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TAIL   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BEFORE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd4;

  // read value reported for failed reads and for every non-read item
  localparam logic [DATA_W-1:0] RV_NONE = '1;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic              read_ok;
    logic              applied;
    logic              full_drop;
  } ils_res_t;

endpackage

// ===== design/ils_ram.sv =====
`timescale 1ns / 1ps

module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ils_ctrl.sv =====
`timescale 1ns / 1ps

module ils_ctrl #(
  parameter int CAPACITY = 1024,
  localparam int AW      = $clog2(CAPACITY),
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ils_pkg::KIND_W-1:0]    kind_i,
  input  logic [ils_pkg::POS_W-1:0]     position_i,
  input  logic [ils_pkg::DATA_W-1:0]    item_value_i,
  output logic                          mem_we_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output logic [ils_pkg::DATA_W-1:0]    mem_wdata_o,
  output logic [AW-1:0]                 mem_raddr_o,
  input  logic [ils_pkg::DATA_W-1:0]    mem_rdata_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output ils_pkg::ils_res_t             res_o,
  output logic [CW-1:0]                 count_o
);

  localparam int CMP_W = (CW > ils_pkg::POS_W) ? CW : ils_pkg::POS_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SHIFT,
    ST_INS_WR,
    ST_RDATA,
    ST_DONE
  } state_e;

  state_e                         state_q;
  logic [CW-1:0]                  count_q;
  logic [ils_pkg::KIND_W-1:0]     kind_q;
  logic [ils_pkg::POS_W-1:0]      pos_q;
  logic [ils_pkg::DATA_W-1:0]     val_q;
  logic [AW-1:0]                  ptr_q;
  logic [AW-1:0]                  at_q;
  logic                           ins_q;
  ils_pkg::ils_res_t              res_q;

  logic             pos_neg;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] cnt_c;
  logic [CMP_W-1:0] at_c;
  logic [AW-1:0]    pos_a;
  logic [AW-1:0]    cnt_m1;
  logic             rd_ok;
  logic             is_full;
  logic             ins_go;
  logic             ins_direct;
  logic             del_last;

  // decode the held item against the current length
  always_comb begin
    pos_neg = pos_q[ils_pkg::POS_W-1];
    pos_c   = CMP_W'(pos_q[ils_pkg::POS_W-2:0]);
    cnt_c   = CMP_W'(count_q);
    pos_a   = pos_c[AW-1:0];
    cnt_m1  = AW'(count_q - CW'(1));
    rd_ok   = !pos_neg && (pos_c < cnt_c);
    is_full = (count_q == CW'(CAPACITY));
    del_last = ((pos_c + CMP_W'(1)) == cnt_c);
    ins_go  = 1'b0;
    at_c    = '0;
    unique case (kind_q)
      ils_pkg::KIND_HEAD: begin
        ins_go = 1'b1;
      end
      ils_pkg::KIND_TAIL: begin
        ins_go = 1'b1;
        at_c   = cnt_c;
      end
      ils_pkg::KIND_BEFORE: begin
        if (pos_neg || pos_c == '0) begin
          ins_go = 1'b1;
        end else if (pos_c <= cnt_c) begin
          ins_go = 1'b1;
          at_c   = pos_c;
        end
      end
      default: begin
        ins_go = 1'b0;
      end
    endcase
    ins_direct = ins_go && !is_full && (at_c == cnt_c);
  end

  // memory port control
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = ptr_q;
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = ptr_q;
    unique case (state_q)
      ST_DECIDE: begin
        if (kind_q == ils_pkg::KIND_READ) begin
          mem_raddr_o = pos_a;
        end else if (kind_q == ils_pkg::KIND_DELETE) begin
          mem_raddr_o = pos_a + AW'(1);
        end else begin
          mem_raddr_o = cnt_m1;
        end
        if (ins_direct) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = at_c[AW-1:0];
          mem_wdata_o = val_q;
        end
      end
      ST_SHIFT: begin
        // move the entry read last cycle one slot up (insert) or down (delete)
        mem_we_o    = 1'b1;
        mem_waddr_o = ins_q ? ptr_q + AW'(1) : ptr_q - AW'(1);
        mem_raddr_o = ins_q ? ptr_q - AW'(1) : ptr_q + AW'(1);
      end
      ST_INS_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = at_q;
        mem_wdata_o = val_q;
      end
      default: begin
        mem_we_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      kind_q  <= '0;
      pos_q   <= '0;
      val_q   <= '0;
      ptr_q   <= '0;
      at_q    <= '0;
      ins_q   <= 1'b0;
      res_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            kind_q  <= kind_i;
            pos_q   <= position_i;
            val_q   <= item_value_i;
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          res_q.read_value <= ils_pkg::RV_NONE;
          res_q.read_ok    <= 1'b0;
          res_q.applied    <= 1'b0;
          res_q.full_drop  <= 1'b0;
          state_q          <= ST_DONE;
          if (kind_q == ils_pkg::KIND_READ) begin
            if (rd_ok) begin
              state_q <= ST_RDATA;
            end
          end else if (kind_q == ils_pkg::KIND_DELETE) begin
            if (rd_ok) begin
              res_q.applied <= 1'b1;
              if (del_last) begin
                count_q <= count_q - CW'(1);
              end else begin
                ptr_q   <= pos_a + AW'(1);
                ins_q   <= 1'b0;
                state_q <= ST_SHIFT;
              end
            end
          end else if (ins_go) begin
            if (is_full) begin
              res_q.full_drop <= 1'b1;
            end else begin
              res_q.applied <= 1'b1;
              at_q          <= at_c[AW-1:0];
              if (ins_direct) begin
                count_q <= count_q + CW'(1);
              end else begin
                ptr_q   <= cnt_m1;
                ins_q   <= 1'b1;
                state_q <= ST_SHIFT;
              end
            end
          end
        end
        ST_SHIFT: begin
          if (ins_q) begin
            if (ptr_q == at_q) begin
              state_q <= ST_INS_WR;
            end else begin
              ptr_q <= ptr_q - AW'(1);
            end
          end else begin
            if (ptr_q == cnt_m1) begin
              count_q <= count_q - CW'(1);
              state_q <= ST_DONE;
            end else begin
              ptr_q <= ptr_q + AW'(1);
            end
          end
        end
        ST_INS_WR: begin
          count_q <= count_q + CW'(1);
          state_q <= ST_DONE;
        end
        ST_RDATA: begin
          res_q.read_value <= mem_rdata_i;
          res_q.read_ok    <= 1'b1;
          state_q          <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;
  assign count_o     = count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("length exceeds capacity");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(res_q.applied && res_q.full_drop) &&
                    !(res_q.read_ok && (res_q.applied || res_q.full_drop)))
    else $error("conflicting result flags");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |=> $stable(count_q))
    else $error("length changed while idle");

  a_shift_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |=>
      (state_q == ST_SHIFT) || (state_q == ST_INS_WR) || (state_q == ST_DONE))
    else $error("bad exit from shift");

endmodule

// ===== design/ils_out.sv =====
`timescale 1ns / 1ps

module ils_out #(
  parameter int CW = 11
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       res_valid_i,
  output logic                       res_ready_o,
  input  ils_pkg::ils_res_t          res_i,
  input  logic [CW-1:0]              count_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ils_pkg::DATA_W-1:0] read_value_o,
  output logic                       read_ok_o,
  output logic                       applied_o,
  output logic                       full_drop_o,
  output logic [CW-1:0]              count_now_o
);

  logic              valid_q;
  ils_pkg::ils_res_t res_q;
  logic [CW-1:0]     count_q;

  assign res_ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  // hold the item while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      res_q   <= res_i;
      count_q <= count_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign read_value_o = res_q.read_value;
  assign read_ok_o    = res_q.read_ok;
  assign applied_o    = res_q.applied;
  assign full_drop_o  = res_q.full_drop;
  assign count_now_o  = count_q;

endmodule

// ===== design/indexed_list_store_core.sv =====
`timescale 1ns / 1ps
// Ordered store of up to CAPACITY signed 32-bit values with a length.
// Input channel (in_valid_i / in_stall_o) carries one operation per item:
// read at index, insert at head, append, insert before index, delete.
// Output channel (out_valid_o / out_stall_i) returns one result per item:
// read value (-1 unless a read hit), read_ok, applied, full_drop and the
// length after the operation.
// One item is processed at a time; the values live in a single RAM with
// one write and one registered read port, so inserts and deletes move
// stored values one entry per cycle.
// Steps: a read passes decide, read-data and done; an append or direct
// write is made in decide; an insert at an index shifts entries up from
// the end, then writes the value; a delete shifts entries above it down
// (none for the last). A new item is accepted after the last result leaves.
// The result sits in an output register, so the engine finishes an item
// and takes the next one while the receiver stalls; only when a second
// result is ready and the register is still held does the engine wait.
// Reset clears the length and all handshake state; RAM contents are not
// cleared, since only entries below the length are ever used.
module indexed_list_store_core #(
  parameter int CAPACITY = 1024,
  localparam int AW      = $clog2(CAPACITY),
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ils_pkg::KIND_W-1:0] kind_i,
  input  logic [ils_pkg::POS_W-1:0]  position_i,
  input  logic [ils_pkg::DATA_W-1:0] item_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ils_pkg::DATA_W-1:0] read_value_o,
  output logic                       read_ok_o,
  output logic                       applied_o,
  output logic                       full_drop_o,
  output logic [CW-1:0]              count_now_o
);

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [ils_pkg::DATA_W-1:0] mem_wdata;
  logic [AW-1:0]              mem_raddr;
  logic [ils_pkg::DATA_W-1:0] mem_rdata;
  logic                       res_valid;
  logic                       res_ready;
  ils_pkg::ils_res_t          res;
  logic [CW-1:0]              count;

  ils_ram #(
    .WIDTH (ils_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ils_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .position_i   (position_i),
    .item_value_i (item_value_i),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .count_o      (count)
  );

  ils_out #(
    .CW (CW)
  ) u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_valid_i  (res_valid),
    .res_ready_o  (res_ready),
    .res_i        (res),
    .count_i      (count),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_o (read_value_o),
    .read_ok_o    (read_ok_o),
    .applied_o    (applied_o),
    .full_drop_o  (full_drop_o),
    .count_now_o  (count_now_o)
  );

endmodule
